/* rtl/core/rrcb_pkg.sv */
// Package for the rotated rectangle corner block: field widths, angle
// constants, the CORDIC arctangent table and a small saturation helper.
// No dependencies.
`default_nettype none
package rrcb_pkg;

  localparam int CRD_W  = 24;   // coordinate width, signed fixed point
  localparam int DIM_W  = 23;   // width / height, unsigned fixed point
  localparam int ANG_W  = 17;   // angle, 1/128 degree
  localparam int CW     = 32;   // CORDIC datapath word
  localparam int PROD_W = 56;   // sine/cosine times dimension
  localparam int SUM_W  = 57;
  localparam int UV_W   = 28;   // half extents after rounding
  localparam int ATAN_N = 24;

  localparam logic signed [17:0] FULL_TURN    = 18'sd46080;
  localparam logic signed [17:0] HALF_TURN    = 18'sd23040;
  localparam logic signed [17:0] QUARTER_TURN = 18'sd11520;

  localparam logic signed [CW-1:0] GAIN_Q28 = 32'sd163008219;
  localparam logic signed [SUM_W-1:0] RND_HALF = 57'sd268435456;

  localparam logic signed [CW-1:0] ATAN_Q22 [ATAN_N] = '{
    32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
    32'sd15000234,  32'sd7507429,   32'sd3754631,  32'sd1877430,
    32'sd938729,    32'sd469366,    32'sd234683,   32'sd117342,
    32'sd58671,     32'sd29335,     32'sd14668,    32'sd7334,
    32'sd3667,      32'sd1833,      32'sd917,      32'sd458,
    32'sd229,       32'sd115,       32'sd57,       32'sd29
  };

  // Side data that rides along the CORDIC pipe
  typedef struct packed {
    logic signed [CRD_W-1:0] cx;
    logic signed [CRD_W-1:0] cy;
    logic [DIM_W-1:0]        w;
    logic [DIM_W-1:0]        h;
    logic                    flip;
  } rect_t;

  function automatic logic signed [CRD_W-1:0] sat24(input logic signed [28:0] v);
    logic signed [28:0] hi;
    logic signed [28:0] lo;
    hi = 29'sd8388607;
    lo = -29'sd8388608;
    if (v > hi) begin
      return 24'sd8388607;
    end else if (v < lo) begin
      return -24'sd8388608;
    end else begin
      return v[CRD_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/core/rrcb_if.sv */
// Valid/ready channels for the rectangle input and the corner results.
// Depends on rrcb_pkg.
`default_nettype none
interface rrcb_rect_if import rrcb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [CRD_W-1:0] center_x;
  logic signed [CRD_W-1:0] center_y;
  logic [DIM_W-1:0]        rect_width;
  logic [DIM_W-1:0]        rect_height;
  logic signed [ANG_W-1:0] angle_deg;

  modport source (output valid, center_x, center_y, rect_width, rect_height, angle_deg,
                  input ready);
  modport sink (input valid, center_x, center_y, rect_width, rect_height, angle_deg,
                output ready);
endinterface

interface rrcb_corner_if import rrcb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              corner_index;
  logic signed [CRD_W-1:0] corner_x;
  logic signed [CRD_W-1:0] corner_y;
  logic signed [CRD_W-1:0] edge_mid_x;
  logic signed [CRD_W-1:0] edge_mid_y;
  logic signed [15:0]      box_left;
  logic signed [15:0]      box_top;
  logic [16:0]             box_width;
  logic [16:0]             box_height;
  logic                    last;

  modport source (output valid, corner_index, corner_x, corner_y, edge_mid_x, edge_mid_y,
                  box_left, box_top, box_width, box_height, last,
                  input ready);
  modport sink (input valid, corner_index, corner_x, corner_y, edge_mid_x, edge_mid_y,
                box_left, box_top, box_width, box_height, last,
                output ready);
endinterface
`default_nettype wire

/* rtl/core/rrcb_cordic.sv */
// Pipelined rotation-mode CORDIC, one register stage per iteration.
// Depends on rrcb_pkg.
`default_nettype none
module rrcb_cordic import rrcb_pkg::*; #(
  parameter int STEPS = 16
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   adv,
  input  wire                   in_valid,
  input  rect_t                 in_rect,
  input  wire signed [CW-1:0]   in_z,
  output logic                  out_valid,
  output rect_t                 out_rect,
  output logic signed [CW-1:0]  out_x,
  output logic signed [CW-1:0]  out_y
);

  logic                 vld  [STEPS+1];
  rect_t                rect [STEPS+1];
  logic signed [CW-1:0] x    [STEPS+1];
  logic signed [CW-1:0] y    [STEPS+1];
  logic signed [CW-1:0] z    [STEPS+1];

  assign vld[0]  = in_valid;
  assign rect[0] = in_rect;
  assign x[0]    = GAIN_Q28;
  assign y[0]    = '0;
  assign z[0]    = in_z;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (adv) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rect[i+1] <= rect[i];
        if (z[i] >= 0) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - ATAN_Q22[i];
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + ATAN_Q22[i];
        end
      end
    end
  end

  assign out_valid = vld[STEPS];
  assign out_rect  = rect[STEPS];
  assign out_x     = x[STEPS];
  assign out_y     = y[STEPS];

endmodule
`default_nettype wire

/* rtl/core/rotated_rect_corners_bbox.sv */
// Top level: rotated rectangle to four corner results with edge midpoints
// and integer bounding box. Depends on rrcb_pkg, rrcb_if, rrcb_cordic.
//
//   channel  dir  beat
//   rect     in   one rectangle: center, width, height, angle
//   corner   out  one corner with edge midpoint; box and last on beat 3
//
// A rectangle passes stage 1, the CORDIC pipe, stages 2 to 6 and the output register
// before its first corner is valid. The four-beat output register walks the corners and
// takes the next rectangle only as the last beat is accepted. All pipe stages advance
// together when the tail is empty or handed to the output register; a stall on corner
// freezes the pipe in place once the tail holds a rectangle. Reset clears valid bits
// and the beat counter only.
`default_nettype none
module rotated_rect_corners_bbox import rrcb_pkg::*; #(
  parameter int CORDIC_STEPS    = 16,
  parameter int COORD_FRAC_BITS = 8
) (
  input  wire            clk,
  input  wire            rst,
  rrcb_rect_if.sink      rect,
  rrcb_corner_if.source  corner
);

  logic adv;

  // Stage 1: angle reduction to [-90,90] with flip
  logic signed [17:0] ang;
  logic signed [17:0] ang_r;
  logic signed [17:0] ang_f;
  logic               flip;

  always_comb begin
    ang = 18'(rect.angle_deg);
    if (ang >= HALF_TURN) begin
      ang_r = ang - FULL_TURN;
    end else if (ang < -HALF_TURN) begin
      ang_r = ang + FULL_TURN;
    end else begin
      ang_r = ang;
    end
    if (ang_r > QUARTER_TURN) begin
      ang_f = ang_r - HALF_TURN;
      flip  = 1'b1;
    end else if (ang_r < -QUARTER_TURN) begin
      ang_f = ang_r + HALF_TURN;
      flip  = 1'b1;
    end else begin
      ang_f = ang_r;
      flip  = 1'b0;
    end
  end

  logic                 s1_valid;
  rect_t                s1_rect;
  logic signed [CW-1:0] s1_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= rect.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_rect.cx   <= rect.center_x;
      s1_rect.cy   <= rect.center_y;
      s1_rect.w    <= rect.rect_width;
      s1_rect.h    <= rect.rect_height;
      s1_rect.flip <= flip;
      s1_z         <= CW'(ang_f) <<< 15;
    end
  end

  assign rect.ready = adv;

  logic                 cd_valid;
  rect_t                cd_rect;
  logic signed [CW-1:0] cd_x;
  logic signed [CW-1:0] cd_y;

  rrcb_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s1_valid),
    .in_rect   (s1_rect),
    .in_z      (s1_z),
    .out_valid (cd_valid),
    .out_rect  (cd_rect),
    .out_x     (cd_x),
    .out_y     (cd_y)
  );

  // Stage 2: apply flip, four products
  logic signed [CW-1:0]     sn;
  logic signed [CW-1:0]     cs;
  logic                     s2_valid;
  logic signed [PROD_W-1:0] s2_a, s2_b, s2_c, s2_d;
  logic signed [CRD_W-1:0]  s2_cx, s2_cy;

  assign sn = cd_rect.flip ? -cd_y : cd_y;
  assign cs = cd_rect.flip ? -cd_x : cd_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= cd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_a  <= sn * $signed({1'b0, cd_rect.h});
      s2_b  <= cs * $signed({1'b0, cd_rect.w});
      s2_c  <= cs * $signed({1'b0, cd_rect.h});
      s2_d  <= sn * $signed({1'b0, cd_rect.w});
      s2_cx <= cd_rect.cx;
      s2_cy <= cd_rect.cy;
    end
  end

  // Stage 3: half extents, rounded half up
  logic signed [SUM_W-1:0] su, sv, sp, sq;
  logic                    s3_valid;
  logic signed [UV_W-1:0]  s3_u, s3_v, s3_p, s3_q;
  logic signed [CRD_W-1:0] s3_cx, s3_cy;

  assign su = SUM_W'(s2_a) + SUM_W'(s2_b) + RND_HALF;
  assign sv = SUM_W'(s2_a) - SUM_W'(s2_b) + RND_HALF;
  assign sp = SUM_W'(s2_c) - SUM_W'(s2_d) + RND_HALF;
  assign sq = SUM_W'(s2_c) + SUM_W'(s2_d) + RND_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_u  <= UV_W'(su >>> 29);
      s3_v  <= UV_W'(sv >>> 29);
      s3_p  <= UV_W'(sp >>> 29);
      s3_q  <= UV_W'(sq >>> 29);
      s3_cx <= s2_cx;
      s3_cy <= s2_cy;
    end
  end

  // Stage 4: saturated corners
  logic                    s4_valid;
  logic signed [CRD_W-1:0] s4_px [4];
  logic signed [CRD_W-1:0] s4_py [4];
  logic signed [28:0]      ex, ey, eu, ev, ep, eq;

  assign ex = 29'(s3_cx);
  assign ey = 29'(s3_cy);
  assign eu = 29'(s3_u);
  assign ev = 29'(s3_v);
  assign ep = 29'(s3_p);
  assign eq = 29'(s3_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_px[0] <= sat24(ex - eu);
      s4_py[0] <= sat24(ey + ep);
      s4_px[1] <= sat24(ex + ev);
      s4_py[1] <= sat24(ey - eq);
      s4_px[2] <= sat24(ex + eu);
      s4_py[2] <= sat24(ey - ep);
      s4_px[3] <= sat24(ex - ev);
      s4_py[3] <= sat24(ey + eq);
    end
  end

  // Stage 5: edge midpoints and extremes
  logic signed [CRD_W-1:0] mid_x [4];
  logic signed [CRD_W-1:0] mid_y [4];
  logic signed [CRD_W-1:0] mn_x01, mn_x23, mx_x01, mx_x23;
  logic signed [CRD_W-1:0] mn_y01, mn_y23, mx_y01, mx_y23;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mid_x[k] = CRD_W'((25'(s4_px[k]) + 25'(s4_px[(k + 1) % 4]) + 25'sd1) >>> 1);
      mid_y[k] = CRD_W'((25'(s4_py[k]) + 25'(s4_py[(k + 1) % 4]) + 25'sd1) >>> 1);
    end
    mn_x01 = (s4_px[1] < s4_px[0]) ? s4_px[1] : s4_px[0];
    mn_x23 = (s4_px[3] < s4_px[2]) ? s4_px[3] : s4_px[2];
    mx_x01 = (s4_px[1] > s4_px[0]) ? s4_px[1] : s4_px[0];
    mx_x23 = (s4_px[3] > s4_px[2]) ? s4_px[3] : s4_px[2];
    mn_y01 = (s4_py[1] < s4_py[0]) ? s4_py[1] : s4_py[0];
    mn_y23 = (s4_py[3] < s4_py[2]) ? s4_py[3] : s4_py[2];
    mx_y01 = (s4_py[1] > s4_py[0]) ? s4_py[1] : s4_py[0];
    mx_y23 = (s4_py[3] > s4_py[2]) ? s4_py[3] : s4_py[2];
  end

  logic                    s5_valid;
  logic signed [CRD_W-1:0] s5_px [4];
  logic signed [CRD_W-1:0] s5_py [4];
  logic signed [CRD_W-1:0] s5_mx [4];
  logic signed [CRD_W-1:0] s5_my [4];
  logic signed [CRD_W-1:0] s5_minx, s5_maxx, s5_miny, s5_maxy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (adv) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_px   <= s4_px;
      s5_py   <= s4_py;
      s5_mx   <= mid_x;
      s5_my   <= mid_y;
      s5_minx <= (mn_x23 < mn_x01) ? mn_x23 : mn_x01;
      s5_maxx <= (mx_x23 > mx_x01) ? mx_x23 : mx_x01;
      s5_miny <= (mn_y23 < mn_y01) ? mn_y23 : mn_y01;
      s5_maxy <= (mx_y23 > mx_y01) ? mx_y23 : mx_y01;
    end
  end

  // Stage 6: integer box
  logic signed [CRD_W-1:0] fl_x, fl_y;
  logic signed [25:0]      cl_x, cl_y;
  logic signed [26:0]      bw_x, bw_y;
  logic signed [15:0]      box_l, box_t;
  logic [16:0]             box_w, box_h;

  always_comb begin
    fl_x = s5_minx >>> COORD_FRAC_BITS;
    fl_y = s5_miny >>> COORD_FRAC_BITS;
    cl_x = -((-26'(s5_maxx)) >>> COORD_FRAC_BITS);
    cl_y = -((-26'(s5_maxy)) >>> COORD_FRAC_BITS);
    bw_x = 27'(cl_x) - 27'(fl_x) + 27'sd1;
    bw_y = 27'(cl_y) - 27'(fl_y) + 27'sd1;
    if (fl_x > 24'sd32767) begin
      box_l = 16'sd32767;
    end else if (fl_x < -24'sd32768) begin
      box_l = -16'sd32768;
    end else begin
      box_l = fl_x[15:0];
    end
    if (fl_y > 24'sd32767) begin
      box_t = 16'sd32767;
    end else if (fl_y < -24'sd32768) begin
      box_t = -16'sd32768;
    end else begin
      box_t = fl_y[15:0];
    end
    if (bw_x < 0) begin
      box_w = '0;
    end else if (bw_x > 27'sd131071) begin
      box_w = '1;
    end else begin
      box_w = bw_x[16:0];
    end
    if (bw_y < 0) begin
      box_h = '0;
    end else if (bw_y > 27'sd131071) begin
      box_h = '1;
    end else begin
      box_h = bw_y[16:0];
    end
  end

  logic                    s6_valid;
  logic signed [CRD_W-1:0] s6_px [4];
  logic signed [CRD_W-1:0] s6_py [4];
  logic signed [CRD_W-1:0] s6_mx [4];
  logic signed [CRD_W-1:0] s6_my [4];
  logic signed [15:0]      s6_bl, s6_bt;
  logic [16:0]             s6_bw, s6_bh;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (adv) begin
      s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_px <= s5_px;
      s6_py <= s5_py;
      s6_mx <= s5_mx;
      s6_my <= s5_my;
      s6_bl <= box_l;
      s6_bt <= box_t;
      s6_bw <= box_w;
      s6_bh <= box_h;
    end
  end

  // Output register: hold one rectangle and walk its four beats
  logic                    busy;
  logic [1:0]              idx;
  logic                    take;
  logic signed [CRD_W-1:0] o_px [4];
  logic signed [CRD_W-1:0] o_py [4];
  logic signed [CRD_W-1:0] o_mx [4];
  logic signed [CRD_W-1:0] o_my [4];
  logic signed [15:0]      o_bl, o_bt;
  logic [16:0]             o_bw, o_bh;

  assign take = s6_valid && (!busy || (corner.ready && idx == 2'd3));
  assign adv  = !s6_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (take) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && corner.ready) begin
      idx <= idx + 2'd1;
      if (idx == 2'd3) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      o_px <= s6_px;
      o_py <= s6_py;
      o_mx <= s6_mx;
      o_my <= s6_my;
      o_bl <= s6_bl;
      o_bt <= s6_bt;
      o_bw <= s6_bw;
      o_bh <= s6_bh;
    end
  end

  assign corner.valid        = busy;
  assign corner.corner_index = idx;
  assign corner.corner_x     = o_px[idx];
  assign corner.corner_y     = o_py[idx];
  assign corner.edge_mid_x   = o_mx[idx];
  assign corner.edge_mid_y   = o_my[idx];
  assign corner.last         = (idx == 2'd3);
  assign corner.box_left     = corner.last ? o_bl : '0;
  assign corner.box_top      = corner.last ? o_bt : '0;
  assign corner.box_width    = corner.last ? o_bw : '0;
  assign corner.box_height   = corner.last ? o_bh : '0;

  // An accepted beat short of the last advances the corner counter
  assert property (@(posedge clk) disable iff (rst)
    busy && corner.ready && idx != 2'd3 |=> busy && idx == 2'($past(idx) + 2'd1))
    else $error("corner counter did not advance");

  // A stalled beat keeps its corner
  assert property (@(posedge clk) disable iff (rst)
    busy && !corner.ready |=> busy && $stable(idx))
    else $error("stalled corner moved");

  // A finished rectangle waiting at the tail stays put while the pipe is frozen
  assert property (@(posedge clk) disable iff (rst)
    s6_valid && !adv |=> s6_valid)
    else $error("tail rectangle dropped during stall");

endmodule
`default_nettype wire
